### hdl/fafc_pkg.sv
// Shared types and constants for the fully associative FIFO cache
`default_nettype none

package fafc_pkg;

  localparam int unsigned WORD_W          = 32;
  localparam int unsigned LINES_DEF       = 16;
  localparam int unsigned BLOCK_WORDS_DEF = 8;

  // func codes of an input beat
  localparam logic [1:0] FUNC_READ   = 2'd0;
  localparam logic [1:0] FUNC_WRITE  = 2'd1;
  localparam logic [1:0] FUNC_REFILL = 2'd2;

  // kind codes of a result beat
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WRITE = 2'd1;
  localparam logic [1:0] KIND_FILL  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [WORD_W-1:0] address;
    logic [WORD_W-1:0] write_value;
    logic [WORD_W-1:0] fill_word;
  } fafc_in_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [WORD_W-1:0] out_address;
    logic [WORD_W-1:0] out_data;
    logic              hit;
    logic              last;
    logic [WORD_W-1:0] query_count;
    logic [WORD_W-1:0] miss_count;
  } fafc_out_t;

endpackage

`default_nettype wire

### hdl/fafc_ram.sv
// Generic simple dual-port RAM, one write port, one registered read port
`default_nettype none

module fafc_ram #(
  parameter int WIDTH = fafc_pkg::WORD_W,
  parameter int DEPTH = fafc_pkg::LINES_DEF * fafc_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

### hdl/fully_associative_fifo_cache.sv
// Fully associative cache, FIFO replacement, write-through, write-allocate
//
//   channel  ports                      handshake
//   input    start, busy, in_item       beat taken when start && !busy
//   result   out_valid, out_item        one-cycle strobe, no back-pressure
//
// For a hit access, or the last refill word of a read miss, the beat is registered,
// all tags are compared in parallel, and the result is registered the next cycle
// (read data comes from the word RAM's registered port in that same cycle).
// A miss holds busy while its fill requests go out, one per cycle: a read miss sends
// the first with its own result, a write miss sends the write-through beat first.
// Synchronous active-low reset clears valid bits, counters and refill state.
// The receiver cannot stall; results are never held back.
`default_nettype none

module fully_associative_fifo_cache #(
  parameter int LINES       = fafc_pkg::LINES_DEF,
  parameter int BLOCK_WORDS = fafc_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire fafc_pkg::fafc_in_t in_item,
  output logic                    out_valid,
  output fafc_pkg::fafc_out_t     out_item
);

  import fafc_pkg::*;

  localparam int OFF_W  = $clog2(BLOCK_WORDS);
  localparam int IDX_W  = (BLOCK_WORDS > 1) ? OFF_W : 1;
  localparam int LINE_W = (LINES > 1) ? $clog2(LINES) : 1;
  localparam int TAG_W  = WORD_W - OFF_W;
  localparam int DEPTH  = LINES * BLOCK_WORDS;
  localparam int RAM_AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [WORD_W-1:0] OFF_MASK  = WORD_W'(BLOCK_WORDS - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(BLOCK_WORDS - 1);
  localparam logic [LINE_W-1:0] HEAD_LAST = LINE_W'(LINES - 1);
  localparam logic              MULTI     = (BLOCK_WORDS > 1);

  function automatic logic [RAM_AW-1:0] word_addr(input logic [LINE_W-1:0] line,
                                                  input logic [IDX_W-1:0]  off);
    word_addr = RAM_AW'(RAM_AW'(line) * RAM_AW'(BLOCK_WORDS)) + RAM_AW'(off);
  endfunction

  // input register
  logic              in_v_r;
  fafc_in_t          in_r;

  // line state
  logic [TAG_W-1:0]  tag_r [LINES];
  logic [LINES-1:0]  valid_r, valid_nxt;
  logic [LINE_W-1:0] head_r, head_nxt;

  // refill state
  logic              pend_r, pend_nxt;
  logic              pend_rd_r, pend_rd_nxt;
  logic [WORD_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [IDX_W-1:0]  fill_idx_r, fill_idx_nxt;

  // counters
  logic [WORD_W-1:0] acc_r, acc_nxt;
  logic [WORD_W-1:0] miss_r, miss_nxt;

  // fill request sequencer
  logic              seq_act_r, seq_act_nxt;
  logic [IDX_W-1:0]  seq_idx_r, seq_idx_nxt;

  // result register
  logic              out_v_r, out_v_nxt;
  fafc_out_t         res_r, res_nxt;
  logic              sel_ram_r, sel_ram_nxt;

  // lookup
  logic [TAG_W-1:0]  req_tag;
  logic [IDX_W-1:0]  req_off;
  logic [IDX_W-1:0]  pend_off;
  logic [LINES-1:0]  match;
  logic              hit_any;
  logic [LINE_W-1:0] hit_line;
  logic              is_acc, is_wr, is_fill, fill_done, miss, tag_we;

  // word RAM
  logic              ram_we, ram_re;
  logic [RAM_AW-1:0] ram_waddr, ram_raddr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;

  assign req_tag  = TAG_W'(in_r.address >> OFF_W);
  assign req_off  = IDX_W'(in_r.address & OFF_MASK);
  assign pend_off = IDX_W'(pend_addr_r & OFF_MASK);

  always_comb begin
    hit_line = '0;
    for (int i = 0; i < LINES; i++) begin
      match[i] = valid_r[i] && (tag_r[i] == req_tag);
      // valid tags are unique, so an OR encode is enough
      if (match[i]) begin
        hit_line = hit_line | LINE_W'(i);
      end
    end
  end

  assign hit_any   = |match;
  assign is_acc    = in_v_r && !pend_r &&
                     ((in_r.func == FUNC_READ) || (in_r.func == FUNC_WRITE));
  assign is_wr     = in_r.func == FUNC_WRITE;
  assign is_fill   = in_v_r && pend_r && (in_r.func == FUNC_REFILL);
  assign fill_done = is_fill && (fill_idx_r == IDX_LAST);
  assign miss      = is_acc && !hit_any;
  assign tag_we    = miss;

  assign busy = (seq_act_r && (seq_idx_r != IDX_LAST)) || (miss && (is_wr || MULTI));

  always_comb begin
    acc_nxt       = acc_r + WORD_W'(is_acc);
    miss_nxt      = miss_r + WORD_W'(miss);
    valid_nxt     = valid_r;
    head_nxt      = head_r;
    pend_nxt      = pend_r;
    pend_rd_nxt   = pend_rd_r;
    pend_addr_nxt = pend_addr_r;
    fill_idx_nxt  = fill_idx_r;
    seq_act_nxt   = seq_act_r;
    seq_idx_nxt   = seq_idx_r;
    out_v_nxt     = 1'b0;
    res_nxt       = res_r;
    sel_ram_nxt   = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = word_addr(hit_line, req_off);
    ram_wdata     = in_r.write_value;
    ram_raddr     = word_addr(hit_line, req_off);

    if (seq_act_r) begin
      out_v_nxt           = 1'b1;
      res_nxt.kind        = KIND_FILL;
      res_nxt.out_address = (pend_addr_r & ~OFF_MASK) | WORD_W'(seq_idx_r);
      res_nxt.out_data    = '0;
      res_nxt.hit         = 1'b0;
      res_nxt.last        = seq_idx_r == IDX_LAST;
      res_nxt.query_count = acc_r;
      res_nxt.miss_count  = miss_r;
      if (seq_idx_r == IDX_LAST) begin
        seq_act_nxt = 1'b0;
      end else begin
        seq_idx_nxt = seq_idx_r + IDX_W'(1);
      end
    end else if (is_acc) begin
      out_v_nxt           = 1'b1;
      res_nxt.out_address = in_r.address;
      res_nxt.query_count = acc_nxt;
      // the write-through beat goes out before the miss is counted
      res_nxt.miss_count  = is_wr ? miss_r : miss_nxt;
      res_nxt.hit         = hit_any;
      if (is_wr) begin
        res_nxt.kind     = KIND_WRITE;
        res_nxt.out_data = in_r.write_value;
        res_nxt.last     = hit_any;
        ram_we           = hit_any;
      end else if (hit_any) begin
        res_nxt.kind     = KIND_READ;
        res_nxt.out_data = '0;
        res_nxt.last     = 1'b1;
        ram_re           = 1'b1;
        sel_ram_nxt      = 1'b1;
      end else begin
        res_nxt.kind        = KIND_FILL;
        res_nxt.out_address = in_r.address & ~OFF_MASK;
        res_nxt.out_data    = '0;
        res_nxt.last        = !MULTI;
      end
      if (miss) begin
        valid_nxt[head_r] = 1'b0;
        pend_nxt          = 1'b1;
        pend_rd_nxt       = !is_wr;
        pend_addr_nxt     = in_r.address;
        fill_idx_nxt      = '0;
        seq_act_nxt       = is_wr || MULTI;
        seq_idx_nxt       = is_wr ? '0 : IDX_W'(1);
      end
    end else if (is_fill) begin
      ram_we    = 1'b1;
      ram_waddr = word_addr(head_r, fill_idx_r);
      ram_wdata = in_r.fill_word;
      ram_raddr = word_addr(head_r, pend_off);
      if (fill_done) begin
        valid_nxt[head_r] = 1'b1;
        pend_nxt          = 1'b0;
        fill_idx_nxt      = '0;
        head_nxt          = (head_r == HEAD_LAST) ? '0 : head_r + LINE_W'(1);
        if (pend_rd_r) begin
          out_v_nxt           = 1'b1;
          res_nxt.kind        = KIND_READ;
          res_nxt.out_address = pend_addr_r;
          res_nxt.out_data    = in_r.fill_word;
          res_nxt.hit         = 1'b0;
          res_nxt.last        = 1'b1;
          res_nxt.query_count = acc_r;
          res_nxt.miss_count  = miss_r;
          // the word being written this cycle bypasses the RAM
          ram_re              = pend_off != IDX_LAST;
          sel_ram_nxt         = pend_off != IDX_LAST;
        end
      end else begin
        fill_idx_nxt = fill_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r      <= 1'b0;
      valid_r     <= '0;
      head_r      <= '0;
      pend_r      <= 1'b0;
      pend_rd_r   <= 1'b0;
      pend_addr_r <= '0;
      fill_idx_r  <= '0;
      acc_r       <= '0;
      miss_r      <= '0;
      seq_act_r   <= 1'b0;
      seq_idx_r   <= '0;
      out_v_r     <= 1'b0;
      sel_ram_r   <= 1'b0;
    end else begin
      in_v_r      <= start && !busy;
      valid_r     <= valid_nxt;
      head_r      <= head_nxt;
      pend_r      <= pend_nxt;
      pend_rd_r   <= pend_rd_nxt;
      pend_addr_r <= pend_addr_nxt;
      fill_idx_r  <= fill_idx_nxt;
      acc_r       <= acc_nxt;
      miss_r      <= miss_nxt;
      seq_act_r   <= seq_act_nxt;
      seq_idx_r   <= seq_idx_nxt;
      out_v_r     <= out_v_nxt;
      sel_ram_r   <= sel_ram_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_r <= in_item;
    end
    if (tag_we) begin
      tag_r[head_r] <= req_tag;
    end
    res_r <= res_nxt;
  end

  fafc_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_words (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_v_r;

  always_comb begin
    out_item = res_r;
    if (sel_ram_r) begin
      out_item.out_data = ram_rdata;
    end
  end

`ifndef ASSERT_OFF
  a_seq_needs_refill: assert property (@(posedge clk) disable iff (!rst_n)
    seq_act_r |-> pend_r)
    else $error("fill sequencer active without a pending refill");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_v_r && seq_act_r))
    else $error("input beat in flight while fill requests are going out");

  a_unique_hit: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r |-> $onehot0(match))
    else $error("tag found in more than one valid line");

  a_miss_counts: assert property (@(posedge clk) disable iff (!rst_n)
    miss |=> (miss_r == $past(miss_r) + 32'd1) && pend_r)
    else $error("miss did not count or did not start a refill");
`endif

endmodule

`default_nettype wire
